// ===== hw/rtl/pfg_pkg.sv =====
// shared constants for the particle field gather and push block
package pfg_pkg;

    localparam int GRID_CELLS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 18;

    localparam int CMD_W    = 1;
    localparam int IDX_W    = 7;
    localparam int FIELD_W  = 32;
    localparam int POS_W    = 24;
    localparam int VEL_W    = 32;
    localparam int GAIN_W   = 20;
    localparam int GAIN_FRAC = 16;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 88;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_KICK_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIES_SIGN = 2'd2;

    localparam logic [GAIN_W-1:0] KICK_GAIN_RST  = 20'd106243;
    localparam logic [GAIN_W-1:0] DRIFT_GAIN_RST = 20'd20861;
    localparam logic              SPECIES_RST    = 1'b0;

    localparam logic SPECIES_ELECTRON = 1'b0;
    localparam logic SPECIES_ION      = 1'b1;

    localparam logic [CMD_W-1:0] CMD_WRITE_NODE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PUSH       = 1'b1;

endpackage

// ===== hw/rtl/pfg_ram.sv =====
// generic ram, one write port and two registered read ports
module pfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/pfg_mod_const.sv =====
// three-stage remainder by a constant modulus, reciprocal multiply and one correction
module pfg_mod_const #(
    parameter int IN_W    = 6,
    parameter int MODULUS = 64
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [IN_W-1:0]            x,
    output logic [$clog2(MODULUS)-1:0] r
);

    localparam int RW = $clog2(MODULUS);
    localparam int SH = IN_W + RW + 1;
    localparam int MW = IN_W + 2;
    localparam int PW = IN_W + MW;
    localparam int W2 = IN_W + RW;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << SH) / 64'(MODULUS);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

    logic [IN_W-1:0] x1_reg;
    logic [IN_W-1:0] q1_reg;
    logic [RW:0]     r2_reg;
    logic [RW-1:0]   r3_reg;

    logic [PW-1:0]   prod_next;
    logic [IN_W-1:0] q_next;
    logic [W2-1:0]   qm_next;
    logic [W2-1:0]   diff_next;
    logic [RW:0]     r2_next;
    logic [RW-1:0]   r3_next;

    always_comb begin
        prod_next = PW'(x) * PW'(RECIP);
        q_next    = IN_W'(prod_next >> SH);
        qm_next   = W2'(q1_reg) * W2'(MODULUS);
        diff_next = W2'(x1_reg) - qm_next;
        r2_next   = diff_next[RW:0];
        if (r2_reg >= (RW+1)'(MODULUS)) begin
            r3_next = RW'(r2_reg - (RW+1)'(MODULUS));
        end else begin
            r3_next = r2_reg[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x;
            q1_reg <= q_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
        end
    end

    assign r = r3_reg;

endmodule

// ===== hw/rtl/pic_field_gather_push.sv =====
// top level: field grid load, linear gather, kick, drift and periodic wrap
//
//   channel  dir  fields (lowest bit first)
//   s_       in   tuser: cmd; tdata: node_index, field_value, position, velocity, pad
//   m_       out  tdata: new_position, new_velocity, gathered_field
//   cfg_     in   cfg_we, cfg_index, cfg_wdata (kick_gain, drift_gain, species_sign)
//
// one request enters per cycle while s_tready is high; a push result passes through the
// 16 register stages and then the output register onto m_; the stages hold two remainder
// units, the field ram read and four multipliers
// node writes reach the field ram in stage four, in order with the reads of pushes
// reset is synchronous; the field ram is not cleared and holds nothing until written
// a stall holds every stage only while the last stage and the output register are both full and m_tready is low
module pic_field_gather_push
    import pfg_pkg::*;
#(
    parameter int GRID_CELLS = GRID_CELLS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // node_index, field_value, position, velocity
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // new_position, new_velocity, gathered_field
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW     = (FRAC_BITS >= POS_W) ? 1 : POS_W - FRAC_BITS;
    localparam int PX     = FRAC_BITS + CW;
    localparam int GW     = $clog2(GRID_CELLS);
    localparam int AW     = $clog2(GRID_CELLS + 1);
    localparam int PW     = FIELD_W + FRAC_BITS + 1;
    localparam int KPW    = FIELD_W + GAIN_W + 1;
    localparam int KW     = KPW - GAIN_FRAC;
    localparam int DPW    = VEL_W + GAIN_W + 1;
    localparam int SD     = VEL_W - FRAC_BITS;
    localparam int OFF_W  = GAIN_W;
    localparam int OFFSET = ((2**OFF_W + GRID_CELLS - 1) / GRID_CELLS) * GRID_CELLS;
    localparam int TW     = OFF_W + 2;
    localparam int POW    = TW + FRAC_BITS;
    localparam int SUMW   = DPW + 1;
    localparam int LAST   = 16;

    localparam logic [FRAC_BITS:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW:0]        HALF_G = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [KPW-1:0]     HALF_K = KPW'(1) << (GAIN_FRAC - 1);
    localparam logic [DPW-1:0]     HALF_D = DPW'(1) << (SD - 1);

    // configuration
    logic [GAIN_W-1:0] kick_gain_reg;
    logic [GAIN_W-1:0] drift_gain_reg;
    logic              species_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_gain_reg  <= KICK_GAIN_RST;
            drift_gain_reg <= DRIFT_GAIN_RST;
            species_reg    <= SPECIES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KICK_GAIN:    kick_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_DRIFT_GAIN:   drift_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_SPECIES_SIGN: species_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline state
    logic [LAST:1]           vld_reg;
    logic [CMD_W-1:0]        cmd_reg   [1:4];
    logic [IDX_W-1:0]        idx_reg   [1:4];
    logic [FIELD_W-1:0]      fv_reg    [1:4];
    logic [FRAC_BITS-1:0]    frac_reg  [1:12];
    logic [VEL_W-1:0]        vel_reg   [1:9];
    logic [TW-1:0]           cofs_reg  [5:12];
    logic [FIELD_W-1:0]      g_reg     [7:16];
    logic [VEL_W-1:0]        nv_reg    [10:16];
    logic [FRAC_BITS-1:0]    nfrac_reg [13:16];
    logic [CW-1:0]           cin_reg;
    logic signed [PW-1:0]    p0_reg;
    logic signed [PW-1:0]    p1_reg;
    logic signed [KPW-1:0]   kp_reg;
    logic signed [KW-1:0]    kick_reg;
    logic signed [DPW-1:0]   dp_reg;
    logic signed [DPW-1:0]   disp_reg;
    logic [TW-1:0]           t_reg;

    logic                    m_valid_reg;
    logic [POS_W-1:0]        m_pos_reg;
    logic [VEL_W-1:0]        m_vel_reg;
    logic [FIELD_W-1:0]      m_g_reg;

    logic                    en;
    logic [PX-1:0]           pos_x;
    logic [GW-1:0]           cell4;
    logic [GW-1:0]           cell16;
    logic                    ram_we;
    logic [FIELD_W-1:0]      e0;
    logic [FIELD_W-1:0]      e1;

    logic [TW-1:0]           cofs_next;
    logic [FRAC_BITS:0]      w0;
    logic signed [PW-1:0]    p0_next;
    logic signed [PW-1:0]    p1_next;
    logic signed [PW:0]      acc;
    logic signed [PW:0]      accr;
    logic [FIELD_W-1:0]      g_next;
    logic signed [KPW-1:0]   kp_next;
    logic signed [KPW-1:0]   kpr;
    logic signed [KW-1:0]    kick_next;
    logic signed [KW+1:0]    vs;
    logic [VEL_W-1:0]        nv_next;
    logic signed [DPW-1:0]   dp_next;
    logic signed [DPW-1:0]   dpr;
    logic signed [DPW-1:0]   disp_next;
    logic [POW-1:0]          pos_off;
    logic signed [SUMW-1:0]  npo;
    logic [TW-1:0]           t_next;
    logic [FRAC_BITS-1:0]    nfrac_next;
    logic [POS_W-1:0]        npos_next;

    assign en       = !(vld_reg[LAST] && m_valid_reg && !m_tready);
    assign s_tready = en;
    assign pos_x    = PX'(s_tdata[62:39]);

    pfg_mod_const #(
        .IN_W    (CW),
        .MODULUS (GRID_CELLS)
    ) u_cell_mod (
        .aclk (aclk),
        .en   (en),
        .x    (cin_reg),
        .r    (cell4)
    );

    assign ram_we = en && vld_reg[4] && (cmd_reg[4] == CMD_WRITE_NODE)
                    && (32'(idx_reg[4]) <= 32'(GRID_CELLS));

    pfg_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (GRID_CELLS + 1)
    ) u_field_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (AW'(idx_reg[4])),
        .wdata   (fv_reg[4]),
        .rd_en   (en),
        .raddr_a (AW'(cell4)),
        .raddr_b (AW'(cell4) + AW'(1)),
        .rdata_a (e0),
        .rdata_b (e1)
    );

    pfg_mod_const #(
        .IN_W    (TW),
        .MODULUS (GRID_CELLS)
    ) u_wrap_mod (
        .aclk (aclk),
        .en   (en),
        .x    (t_reg),
        .r    (cell16)
    );

    always_comb begin
        cofs_next = TW'(cell4) + TW'(OFFSET);
        // linear weights
        w0        = ONE - {1'b0, frac_reg[5]};
        p0_next   = $signed(e0) * $signed({1'b0, w0});
        p1_next   = $signed(e1) * $signed({2'b00, frac_reg[5]});
        acc       = (PW+1)'(p0_reg) + (PW+1)'(p1_reg);
        accr      = acc + $signed(HALF_G);
        g_next    = FIELD_W'(accr >>> FRAC_BITS);
        // kick
        kp_next   = $signed(g_reg[7]) * $signed({1'b0, kick_gain_reg});
        kpr       = kp_reg + $signed(HALF_K);
        kick_next = KW'(kpr >>> GAIN_FRAC);
        if (species_reg == SPECIES_ION) begin
            vs = (KW+2)'($signed(vel_reg[9])) + (KW+2)'(kick_reg);
        end else begin
            vs = (KW+2)'($signed(vel_reg[9])) - (KW+2)'(kick_reg);
        end
        if (vs[KW+1:VEL_W-1] == '0 || vs[KW+1:VEL_W-1] == '1) begin
            nv_next = vs[VEL_W-1:0];
        end else begin
            nv_next = {vs[KW+1], {(VEL_W-1){!vs[KW+1]}}};
        end
        // drift and wrap
        dp_next    = $signed(nv_reg[10]) * $signed({1'b0, drift_gain_reg});
        dpr        = dp_reg + $signed(HALF_D);
        disp_next  = dpr >>> SD;
        pos_off    = {cofs_reg[12], frac_reg[12]};
        npo        = SUMW'(disp_reg) + $signed(SUMW'(pos_off));
        t_next     = npo[FRAC_BITS +: TW];
        nfrac_next = npo[FRAC_BITS-1:0];
        npos_next  = POS_W'({cell16, nfrac_reg[16]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg[1]      <= s_tvalid;
            vld_reg[4:2]    <= vld_reg[3:1];
            vld_reg[5]      <= vld_reg[4] && (cmd_reg[4] == CMD_PUSH);
            vld_reg[LAST:6] <= vld_reg[LAST-1:5];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg[1]   <= s_tuser;
            idx_reg[1]   <= s_tdata[6:0];
            fv_reg[1]    <= s_tdata[38:7];
            vel_reg[1]   <= s_tdata[94:63];
            cin_reg      <= pos_x[PX-1:FRAC_BITS];
            frac_reg[1]  <= pos_x[FRAC_BITS-1:0];
            for (int i = 2; i <= 4; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
                idx_reg[i] <= idx_reg[i-1];
                fv_reg[i]  <= fv_reg[i-1];
            end
            for (int i = 2; i <= 12; i++) begin
                frac_reg[i] <= frac_reg[i-1];
            end
            for (int i = 2; i <= 9; i++) begin
                vel_reg[i] <= vel_reg[i-1];
            end
            cofs_reg[5] <= cofs_next;
            for (int i = 6; i <= 12; i++) begin
                cofs_reg[i] <= cofs_reg[i-1];
            end
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            g_reg[7] <= g_next;
            for (int i = 8; i <= 16; i++) begin
                g_reg[i] <= g_reg[i-1];
            end
            kp_reg    <= kp_next;
            kick_reg  <= kick_next;
            nv_reg[10] <= nv_next;
            for (int i = 11; i <= 16; i++) begin
                nv_reg[i] <= nv_reg[i-1];
            end
            dp_reg        <= dp_next;
            disp_reg      <= disp_next;
            t_reg         <= t_next;
            nfrac_reg[13] <= nfrac_next;
            for (int i = 14; i <= 16; i++) begin
                nfrac_reg[i] <= nfrac_reg[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && vld_reg[LAST]) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[LAST]) begin
            m_pos_reg <= npos_next;
            m_vel_reg <= nv_reg[16];
            m_g_reg   <= g_reg[16];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_g_reg, m_vel_reg, m_pos_reg};

    a_cell_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && cmd_reg[4] == CMD_PUSH) |-> (32'(cell4) < 32'(GRID_CELLS)))
        else $error("gather cell out of range");

    a_wrap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAST] |-> (32'(cell16) < 32'(GRID_CELLS)))
        else $error("wrapped cell out of range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(vld_reg[LAST]))
        else $error("result without a finished push");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== test/tb.sv =====
// testbench for the particle field gather and push block, checked against a built-in predictor
`timescale 1ns / 100ps

module tb;
    import pfg_pkg::*;

    localparam int     NODES  = GRID_CELLS_DEF + 1;
    localparam int     FRAC   = FRAC_BITS_DEF;
    localparam longint ONE    = longint'(1) << FRAC;
    localparam longint DOMAIN = longint'(GRID_CELLS_DEF) << FRAC;
    localparam int     LIMIT  = 400000;
    localparam int     PHASES = 8;
    localparam int     PER_PHASE = 235;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] field;
        logic [POS_W-1:0]   pos;
        logic [VEL_W-1:0]   vel;
    } pic_req_t;

    typedef struct packed {
        logic [POS_W-1:0]   npos;
        logic [VEL_W-1:0]   nvel;
        logic [FIELD_W-1:0] gfield;
    } pic_res_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pic_field_gather_push u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pic_req_t       cmd_q[$];
    pic_res_t       push_exp_q[$];
    pic_req_t       cur_req;
    int             field_mem[NODES];
    logic [19:0]    kick_g   = KICK_GAIN_RST;
    logic [19:0]    drift_g  = DRIFT_GAIN_RST;
    logic           ion_sel  = SPECIES_RST;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             bad_count = 0;
    int             cyc = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // gather, kick, drift and wrap for one particle
    function automatic pic_res_t push_particle(logic [POS_W-1:0] pos_in,
                                               logic [VEL_W-1:0] vel_in);
        longint   p, fr, e0, e1, acc, g, kick, v, disp, np;
        int       node;
        pic_res_t r;
        p    = longint'(pos_in) % DOMAIN;
        node = int'(p >>> FRAC);
        fr   = p & (ONE - 1);
        e0   = longint'(field_mem[node]);
        e1   = longint'(field_mem[node + 1]);
        acc  = e0 * (ONE - fr) + e1 * fr;
        g    = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        kick = (g * longint'(kick_g) + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        v    = longint'($signed(vel_in));
        if (ion_sel == SPECIES_ION) begin
            v = v + kick;
        end else begin
            v = v - kick;
        end
        if (v > longint'(32'sh7FFFFFFF)) begin
            v = longint'(32'sh7FFFFFFF);
        end
        if (v < -(longint'(1) << 31)) begin
            v = -(longint'(1) << 31);
        end
        disp = (v * longint'(drift_g) + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
        np   = (p + disp) % DOMAIN;
        if (np < 0) begin
            np = np + DOMAIN;
        end
        r.npos   = np[POS_W-1:0];
        r.nvel   = v[VEL_W-1:0];
        r.gfield = g[FIELD_W-1:0];
        return r;
    endfunction

    function automatic pic_req_t mk_write(int idx, logic [31:0] val);
        pic_req_t q;
        q = '0;
        q.cmd   = CMD_WRITE_NODE;
        q.idx   = IDX_W'(idx);
        q.field = val;
        return q;
    endfunction

    function automatic pic_req_t mk_push(logic [POS_W-1:0] pos, logic [VEL_W-1:0] vel);
        pic_req_t q;
        q = '0;
        q.cmd = CMD_PUSH;
        q.pos = pos;
        q.vel = vel;
        return q;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0:       return {{12{w[19]}}, w[19:0]};
            1:       return {w[8], {31{~w[8]}}};
            2:       return {{24{w[7]}}, w[7:0]};
            default: return w;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            return {w[5:0], {18{w[6]}}};
        end
        return w[POS_W-1:0];
    endfunction

    function automatic pic_req_t rand_req();
        pic_req_t q;
        q.cmd   = ($urandom_range(0, 99) < 12) ? CMD_WRITE_NODE : CMD_PUSH;
        q.idx   = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(65, 127))
                                              : IDX_W'($urandom_range(0, NODES - 1));
        q.field = rand_word();
        q.pos   = rand_pos();
        q.vel   = rand_word();
        return q;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_req.cmd == CMD_PUSH) begin
                    push_exp_q.push_back(push_particle(cur_req.pos, cur_req.vel));
                end else if (cur_req.idx < NODES) begin
                    field_mem[cur_req.idx] = $signed(cur_req.field);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_req = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {1'b0, cur_req.vel, cur_req.pos, cur_req.field, cur_req.idx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void report(string what, logic [31:0] want, logic [31:0] got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("mismatch %s: expected %h actual %h", what, want, got);
        end
    endfunction

    // result monitor
    always @(posedge aclk) begin
        pic_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (push_exp_q.size() == 0) begin
                    report("unexpected result", '0, m_tdata[31:0]);
                end else begin
                    want = push_exp_q.pop_front();
                    if (m_tdata[23:0] !== want.npos) begin
                        report("new_position", 32'(want.npos), 32'(m_tdata[23:0]));
                    end
                    if (m_tdata[55:24] !== want.nvel) begin
                        report("new_velocity", want.nvel, m_tdata[55:24]);
                    end
                    if (m_tdata[87:56] !== want.gfield) begin
                        report("gathered_field", want.gfield, m_tdata[87:56]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_KICK_GAIN:  kick_g  = val;
            CFG_DRIFT_GAIN: drift_g = val;
            default:        ion_sel = val[0];
        endcase
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || s_tvalid || push_exp_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        logic [19:0] kg_tab[PHASES];
        logic [19:0] dg_tab[PHASES];
        logic        sp_tab[PHASES];
        kg_tab = '{KICK_GAIN_RST, 20'hFFFFF, 20'd0, 20'd0, 20'($urandom), 20'd1,
                   20'($urandom_range(0, 4095)), 20'($urandom)};
        dg_tab = '{DRIFT_GAIN_RST, 20'hFFFFF, 20'd0, 20'($urandom), 20'd0, 20'd1,
                   20'($urandom), 20'($urandom)};
        sp_tab = '{SPECIES_RST, SPECIES_ION, SPECIES_ELECTRON, SPECIES_ION,
                   SPECIES_ELECTRON, SPECIES_ION, SPECIES_ION, 1'($urandom)};

        // every node gets written before any push can read it
        cmd_q.push_back(mk_write(0, 32'h7FFFFFFF));
        cmd_q.push_back(mk_write(1, 32'h80000000));
        for (int i = 2; i < NODES; i++) begin
            cmd_q.push_back(mk_write(i, rand_word()));
        end
        cmd_q.push_back(mk_write(65, 32'h12345678));
        cmd_q.push_back(mk_write(127, 32'hFFFFFFFF));
        cmd_q.push_back(mk_push(24'h000000, 32'h80000000));
        cmd_q.push_back(mk_push(24'h040000, 32'h7FFFFFFF));
        cmd_q.push_back(mk_push(24'h020000, 32'h00000000));
        cmd_q.push_back(mk_push(24'hFFFFFF, 32'h7FFFFFFF));
        cmd_q.push_back(mk_push(24'hFFFFFF, 32'h80000000));
        cmd_q.push_back(mk_push(24'h03FFFF, 32'h00000000));
        cmd_q.push_back(mk_push(24'h040000, 32'hFFFFFFFF));
        cmd_q.push_back(mk_push(24'hFC0000, 32'h00010000));
        cmd_q.push_back(mk_push(24'h000001, 32'hFFFF0000));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                repeat (24) @(posedge aclk);
                cfg_write(CFG_KICK_GAIN, kg_tab[ph]);
                cfg_write(CFG_DRIFT_GAIN, dg_tab[ph]);
                cfg_write(CFG_SPECIES_SIGN, CFG_DATA_W'(sp_tab[ph]));
                @(posedge aclk);
                cfg_we <= 1'b0;
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                cmd_q.push_back(rand_req());
            end
        end

        drain();
        repeat (24) @(posedge aclk);
        if (bad_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
